// File: sv/mmrs_pkg.sv
// Shared types and constants for the memory map reservation splicer.
package mmrs_pkg;

  localparam int ADDR_W = 64;
  localparam int ATTR_W = 32;
  localparam int REQ_W  = 2;
  localparam int ERR_W  = 2;
  localparam int PTR_W  = 5;

  localparam logic [PTR_W-1:0] PTR_TOP = 5'd31;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REGION = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LIMIT    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic clear;      // empty table, rewind pointer and counters
    logic load;       // append one reservation entry
    logic count_in;   // count one incoming region
    logic capture;    // latch region bounds and attribute for slicing
    logic emit_lim;   // emit region-limit error beat
    logic emit_term;  // emit terminating beat and rewind
    logic step;       // emit one piece of the current region
  } ctl_cmd_t;

  typedef struct packed {
    logic lim_hit;     // incoming region count at its limit
    logic is_term;     // incoming region is all zero
    logic nonempty;    // incoming start below end
    logic piece_last;  // current piece closes the region
  } dp_stat_t;

endpackage

// File: sv/mmrs_ctrl.sv
// Controller state machine: decodes requests and sequences region slicing.
module mmrs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mmrs_pkg::REQ_W-1:0]  req_type,
  input  mmrs_pkg::dp_stat_t          stat,
  output mmrs_pkg::ctl_cmd_t          cmd,
  output logic                        busy
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SLICE = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            mmrs_pkg::REQ_CLEAR: cmd.clear = 1'b1;
            mmrs_pkg::REQ_LOAD:  cmd.load  = 1'b1;
            mmrs_pkg::REQ_REGION: begin
              if (stat.lim_hit) begin
                cmd.emit_lim = 1'b1;
              end else if (stat.is_term) begin
                cmd.emit_term = 1'b1;
              end else begin
                cmd.count_in = 1'b1;
                if (stat.nonempty) begin
                  cmd.capture = 1'b1;
                  state_nxt   = ST_SLICE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SLICE: begin
        cmd.step = 1'b1;
        if (stat.piece_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_SLICE);

endmodule

// File: sv/mmrs_dp.sv
// Datapath: reservation table, pointer, counters, piece slicing and output beat.
module mmrs_dp #(
  parameter int MAX_RESERVATIONS = 16,
  parameter int MAX_REGIONS      = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmrs_pkg::ctl_cmd_t            cmd,
  output mmrs_pkg::dp_stat_t            stat,
  input  logic [mmrs_pkg::ADDR_W-1:0]   in_start,
  input  logic [mmrs_pkg::ADDR_W-1:0]   in_end,
  input  logic [mmrs_pkg::ATTR_W-1:0]   in_attr,
  output logic                          out_valid,
  output logic [mmrs_pkg::ADDR_W-1:0]   out_start,
  output logic [mmrs_pkg::ADDR_W-1:0]   out_end,
  output logic [mmrs_pkg::ATTR_W-1:0]   out_attr,
  output logic                          out_last,
  output logic                          out_mend,
  output logic [mmrs_pkg::ERR_W-1:0]    out_err
);

  localparam int IDX_W = (MAX_RESERVATIONS > 1) ? $clog2(MAX_RESERVATIONS) : 1;
  localparam int LCW   = $clog2(MAX_RESERVATIONS + 1);
  localparam int CW    = $clog2(MAX_REGIONS + 1);
  localparam int AW    = mmrs_pkg::ADDR_W;
  localparam int TW    = mmrs_pkg::ATTR_W;
  localparam int PW    = mmrs_pkg::PTR_W;

  logic [AW-1:0] res_start_r [MAX_RESERVATIONS];
  logic [AW-1:0] res_end_r   [MAX_RESERVATIONS];
  logic [TW-1:0] res_attr_r  [MAX_RESERVATIONS];

  logic [LCW-1:0] loaded_r;
  logic [PW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  in_cnt_r;
  logic [CW-1:0]  emit_cnt_r;
  logic [AW-1:0]  cur_r, cur_nxt;
  logic [AW-1:0]  end_r;
  logic [TW-1:0]  attr_r;

  logic          out_valid_r;
  logic [AW-1:0] out_start_r, out_end_r;
  logic [TW-1:0] out_attr_r;
  logic          out_last_r, out_mend_r;
  logic [mmrs_pkg::ERR_W-1:0] out_err_r;

  logic [AW-1:0] out_start_nxt, out_end_nxt;
  logic [TW-1:0] out_attr_nxt;
  logic          out_last_nxt, out_mend_nxt;
  logic [mmrs_pkg::ERR_W-1:0] out_err_nxt;

  logic          ptr_ok, ovf, full;
  logic [AW-1:0] rs, re;
  logic [TW-1:0] ra;
  logic          c_eq, c_lt, rs_nz, re_lt_e, rs_lt_e, adv;
  logic [AW-1:0] p_start, p_end;
  logic [TW-1:0] p_attr;
  logic          p_last;

  // Reservation at the pointer; entries past the loaded count read as zero.
  assign ptr_ok = (ptr_r < PW'(loaded_r));
  assign rs     = ptr_ok ? res_start_r[ptr_r[IDX_W-1:0]] : '0;
  assign re     = ptr_ok ? res_end_r[ptr_r[IDX_W-1:0]]   : '0;
  assign ra     = ptr_ok ? res_attr_r[ptr_r[IDX_W-1:0]]  : '0;

  assign ovf     = (emit_cnt_r >= CW'(MAX_REGIONS));
  assign full    = (loaded_r >= LCW'(MAX_RESERVATIONS));
  assign c_eq    = (cur_r == rs);
  assign c_lt    = (cur_r < rs);
  assign rs_nz   = (rs != '0);
  assign re_lt_e = (re < end_r);
  assign rs_lt_e = (rs < end_r);

  always_comb begin
    p_start = cur_r;
    p_attr  = attr_r;
    adv     = 1'b0;
    if (c_eq) begin
      p_end  = re_lt_e ? re : end_r;
      p_attr = ra;
      p_last = !re_lt_e;
      adv    = 1'b1;
    end else if (c_lt) begin
      p_end  = rs_lt_e ? rs : end_r;
      p_last = !rs_lt_e;
    end else if (rs_nz) begin
      p_end  = re_lt_e ? re : end_r;
      p_last = !re_lt_e;
      adv    = 1'b1;
    end else begin
      p_end  = end_r;
      p_last = 1'b1;
    end
  end

  assign cur_nxt = p_end;
  assign ptr_nxt = (adv && ptr_r != mmrs_pkg::PTR_TOP) ? PW'(ptr_r + 1'b1) : ptr_r;

  assign stat.lim_hit    = (in_cnt_r >= CW'(MAX_REGIONS));
  assign stat.is_term    = (in_start == '0) && (in_end == '0);
  assign stat.nonempty   = (in_start < in_end);
  assign stat.piece_last = ovf || p_last;

  // Next output beat: error beats and the terminator carry zero bounds.
  always_comb begin
    out_start_nxt = '0;
    out_end_nxt   = '0;
    out_attr_nxt  = '0;
    out_last_nxt  = 1'b1;
    out_mend_nxt  = 1'b0;
    out_err_nxt   = mmrs_pkg::ERR_NONE;
    if (cmd.emit_lim) begin
      out_err_nxt = mmrs_pkg::ERR_LIMIT;
    end else if (cmd.emit_term) begin
      out_mend_nxt = 1'b1;
      out_err_nxt  = ovf ? mmrs_pkg::ERR_OVERFLOW : mmrs_pkg::ERR_NONE;
    end else if (cmd.step) begin
      if (ovf) begin
        out_err_nxt = mmrs_pkg::ERR_OVERFLOW;
      end else begin
        out_start_nxt = p_start;
        out_end_nxt   = p_end;
        out_attr_nxt  = p_attr;
        out_last_nxt  = p_last;
      end
    end
  end

  // Control state: counters, pointer, output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      ptr_r       <= '0;
      in_cnt_r    <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_lim || cmd.emit_term || cmd.step;
      if (cmd.clear) begin
        loaded_r   <= '0;
        ptr_r      <= '0;
        in_cnt_r   <= '0;
        emit_cnt_r <= '0;
      end
      if (cmd.load && !full) begin
        loaded_r <= LCW'(loaded_r + 1'b1);
      end
      if (cmd.emit_term) begin
        ptr_r      <= '0;
        in_cnt_r   <= '0;
        emit_cnt_r <= '0;
      end
      if (cmd.count_in) begin
        in_cnt_r <= CW'(in_cnt_r + 1'b1);
      end
      if (cmd.step && !ovf) begin
        ptr_r      <= ptr_nxt;
        emit_cnt_r <= CW'(emit_cnt_r + 1'b1);
      end
    end
  end

  // Payload: table entries, working region, output beat.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      res_start_r[loaded_r[IDX_W-1:0]] <= in_start;
      res_end_r[loaded_r[IDX_W-1:0]]   <= in_end;
      res_attr_r[loaded_r[IDX_W-1:0]]  <= in_attr;
    end
    if (cmd.capture) begin
      cur_r  <= in_start;
      end_r  <= in_end;
      attr_r <= in_attr;
    end else if (cmd.step && !ovf) begin
      cur_r <= cur_nxt;
    end
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_attr_r  <= out_attr_nxt;
    out_last_r  <= out_last_nxt;
    out_mend_r  <= out_mend_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_start = out_start_r;
  assign out_end   = out_end_r;
  assign out_attr  = out_attr_r;
  assign out_last  = out_last_r;
  assign out_mend  = out_mend_r;
  assign out_err   = out_err_r;

endmodule

// File: sv/memory_map_reservation_splicer.sv
// Top level of the memory map reservation splicer: controller, datapath, checks.
// Clear and load beats never raise busy.
// A region is cut one piece per cycle while busy is high; each piece is registered
// and appears in the cycle after it is cut, the last while busy is already low again.
// Terminator and region-limit beats give their single result the cycle after accept.
// Synchronous active-low reset rewinds counters, pointer and state; table rows are
// not cleared, since rows past the loaded count always read as zero.
module memory_map_reservation_splicer #(
  parameter int MAX_RESERVATIONS = 16,
  parameter int MAX_REGIONS      = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel: beat accepted when start is high and busy is low.
  input  logic                          start,
  output logic                          busy,
  input  logic [mmrs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mmrs_pkg::ADDR_W-1:0]   in_region_start,
  input  logic [mmrs_pkg::ADDR_W-1:0]   in_region_end,
  input  logic [mmrs_pkg::ATTR_W-1:0]   in_region_attr,
  // Result channel: one beat per cycle of out_valid, no back-pressure.
  output logic                          out_valid,
  output logic [mmrs_pkg::ADDR_W-1:0]   out_start,
  output logic [mmrs_pkg::ADDR_W-1:0]   out_end,
  output logic [mmrs_pkg::ATTR_W-1:0]   out_attr,
  output logic                          out_last_of_run,
  output logic                          out_map_end,
  output logic [mmrs_pkg::ERR_W-1:0]    out_error_code
);

  mmrs_pkg::ctl_cmd_t cmd;
  mmrs_pkg::dp_stat_t stat;

  // Controller: decode the request, then walk the region one piece per cycle.
  mmrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Datapath: table, pointer, counters and the registered output beat.
  mmrs_dp #(
    .MAX_RESERVATIONS (MAX_RESERVATIONS),
    .MAX_REGIONS      (MAX_REGIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_start  (in_region_start),
    .in_end    (in_region_end),
    .in_attr   (in_region_attr),
    .out_valid (out_valid),
    .out_start (out_start),
    .out_end   (out_end),
    .out_attr  (out_attr),
    .out_last  (out_last_of_run),
    .out_mend  (out_map_end),
    .out_err   (out_error_code)
  );

  // A result beat always follows an accepted beat or a slicing cycle.
  a_beat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without a cause");

  // The terminating beat is zero-bounded and closes its run.
  a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_map_end) |->
      (out_last_of_run && out_start == '0 && out_end == '0 && out_attr == '0))
    else $error("malformed terminating beat");

  // Any error beat ends the run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != mmrs_pkg::ERR_NONE) |-> out_last_of_run)
    else $error("error beat not last of run");

  // Leaving the slicing state always shows the closing piece.
  a_slice_close: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last_of_run))
    else $error("slicing ended without a last beat");

endmodule

// File: bench/memory_map_reservation_splicer_tb.sv
// Self-checking testbench for the memory map reservation splicer.
`timescale 1ns / 100ps

module memory_map_reservation_splicer_tb;

  localparam int ADDR_W = mmrs_pkg::ADDR_W;
  localparam int ATTR_W = mmrs_pkg::ATTR_W;
  localparam int REQ_W  = mmrs_pkg::REQ_W;
  localparam int ERR_W  = mmrs_pkg::ERR_W;
  localparam int PTR_W  = mmrs_pkg::PTR_W;

  localparam int RSV_DEPTH      = 16;    // reservation table rows
  localparam int REGION_CAP     = 32;    // regions per map and pieces per map
  localparam int RANDOM_ITEMS   = 400;   // stop the random part past this many beats
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES  = 20;    // quiet tail after the last result
  localparam int REPORT_CAP     = 60;    // keep a broken run from flooding the log

  // Request code 3 has no name in the package; the block must ignore it.
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  // One emitted piece as it should appear on the result ports.
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ATTR_W-1:0] attr;
    logic              last;
    logic              map_end;
    logic [ERR_W-1:0]  err;
  } piece_t;

  // One row of the directed script. A pinned row carries its single result typed in;
  // every other row is checked against the splice predictor.
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ATTR_W-1:0] attr;
    int                reps;
    bit                pinned;
    bit                settle;  // hold off until every pending piece has come out
    piece_t            want;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  in_req_type;
  logic [ADDR_W-1:0] in_region_start;
  logic [ADDR_W-1:0] in_region_end;
  logic [ATTR_W-1:0] in_region_attr;
  logic              out_valid;
  logic [ADDR_W-1:0] out_start;
  logic [ADDR_W-1:0] out_end;
  logic [ATTR_W-1:0] out_attr;
  logic              out_last_of_run;
  logic              out_map_end;
  logic [ERR_W-1:0]  out_error_code;

  memory_map_reservation_splicer #(
    .MAX_RESERVATIONS (RSV_DEPTH),
    .MAX_REGIONS      (REGION_CAP)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_region_start (in_region_start),
    .in_region_end   (in_region_end),
    .in_region_attr  (in_region_attr),
    .out_valid       (out_valid),
    .out_start       (out_start),
    .out_end         (out_end),
    .out_attr        (out_attr),
    .out_last_of_run (out_last_of_run),
    .out_map_end     (out_map_end),
    .out_error_code  (out_error_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Splice predictor: its own copy of the reservation table, the walk pointer and
  // the per-map counters, advanced once per accepted beat.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] rsv_lo   [RSV_DEPTH];
  logic [ADDR_W-1:0] rsv_hi   [RSV_DEPTH];
  logic [ATTR_W-1:0] rsv_attr [RSV_DEPTH];
  int unsigned       rsv_count;
  logic [PTR_W-1:0]  walk_ptr;
  int unsigned       regions_seen;
  int unsigned       pieces_out;

  piece_t      due_pieces[$];   // pieces predicted but not yet seen, oldest first
  script_row_t script[$];
  int          mismatches;
  int          beats_sent;
  int          quiet_cycles;
  bit          steady;          // no sender gaps while set

  function automatic piece_t piece(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                                   input logic [ATTR_W-1:0] attr, input logic last,
                                   input logic map_end, input logic [ERR_W-1:0] err);
    piece_t p;
    p.lo      = lo;
    p.hi      = hi;
    p.attr    = attr;
    p.last    = last;
    p.map_end = map_end;
    p.err     = err;
    return p;
  endfunction

  function automatic void forget_map();
    foreach (rsv_lo[i]) begin
      rsv_lo[i]   = '0;
      rsv_hi[i]   = '0;
      rsv_attr[i] = '0;
    end
    rsv_count    = 0;
    walk_ptr     = '0;
    regions_seen = 0;
    pieces_out   = 0;
  endfunction

  // Work out the pieces one beat causes and advance the predictor state.
  function automatic void splice_beat(input logic [REQ_W-1:0] req,
                                      input logic [ADDR_W-1:0] lo,
                                      input logic [ADDR_W-1:0] hi,
                                      input logic [ATTR_W-1:0] attr,
                                      output piece_t cut[$]);
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] re;
    logic [ADDR_W-1:0] ne;
    logic [ATTR_W-1:0] ra;
    cut = {};
    case (req)
      mmrs_pkg::REQ_CLEAR: begin
        forget_map();
      end
      mmrs_pkg::REQ_LOAD: begin
        // A full table drops further entries.
        if (rsv_count < RSV_DEPTH) begin
          rsv_lo[rsv_count]   = lo;
          rsv_hi[rsv_count]   = hi;
          rsv_attr[rsv_count] = attr;
          rsv_count++;
        end
      end
      mmrs_pkg::REQ_REGION: begin
        if (regions_seen >= REGION_CAP) begin
          // Region limit: one error beat, state untouched, terminator included.
          cut.push_back(piece('0, '0, '0, 1'b0, 1'b0, mmrs_pkg::ERR_LIMIT));
        end else if (lo == '0 && hi == '0) begin
          cut.push_back(piece('0, '0, '0, 1'b0, 1'b1,
                              (pieces_out >= REGION_CAP) ? mmrs_pkg::ERR_OVERFLOW
                                                         : mmrs_pkg::ERR_NONE));
          regions_seen = 0;
          pieces_out   = 0;
          walk_ptr     = '0;
        end else begin
          cur = lo;
          regions_seen++;
          while (cur < hi) begin
            if (pieces_out >= REGION_CAP) begin
              // Output overflow: one error beat, drop the rest of the region.
              cut.push_back(piece('0, '0, '0, 1'b0, 1'b0, mmrs_pkg::ERR_OVERFLOW));
              break;
            end
            rs = '0;
            re = '0;
            ra = '0;
            // Rows past the loaded count read as zero, i.e. end of list.
            if (walk_ptr < rsv_count) begin
              rs = rsv_lo[walk_ptr];
              re = rsv_hi[walk_ptr];
              ra = rsv_attr[walk_ptr];
            end
            if (cur == rs) begin
              // Reserved piece carries the reservation's attribute.
              ne = (re < hi) ? re : hi;
              cut.push_back(piece(rs, ne, ra, 1'b0, 1'b0, mmrs_pkg::ERR_NONE));
              cur = ne;
              if (walk_ptr < mmrs_pkg::PTR_TOP) walk_ptr++;
            end else if (cur < rs) begin
              // Gap ahead of the next reservation.
              ne = (hi < rs) ? hi : rs;
              cut.push_back(piece(cur, ne, attr, 1'b0, 1'b0, mmrs_pkg::ERR_NONE));
              cur = ne;
            end else if (rs != '0) begin
              // Reservation began before the cursor.
              ne = (hi < re) ? hi : re;
              cut.push_back(piece(cur, ne, attr, 1'b0, 1'b0, mmrs_pkg::ERR_NONE));
              cur = ne;
              if (walk_ptr < mmrs_pkg::PTR_TOP) walk_ptr++;
            end else begin
              // List ended: the tail goes out whole.
              cut.push_back(piece(cur, hi, attr, 1'b0, 1'b0, mmrs_pkg::ERR_NONE));
              cur = hi;
            end
            pieces_out++;
          end
        end
      end
      default: ;
    endcase
    if (cut.size() > 0) cut[cut.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. All inputs change at the falling edge; a beat is taken at the
  // rising edge where start is high and busy is low.
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = 0;
    if (!steady) begin
      if (pick >= 90) n = $urandom_range(8, 40);
      else if (pick >= 55) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Enter at a falling edge, leave at the falling edge after the beat is taken with
  // start still high, so back-to-back beats never drop start in between.
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] lo,
                           input logic [ADDR_W-1:0] hi, input logic [ATTR_W-1:0] attr,
                           input bit pinned, input piece_t want);
    piece_t cut[$];
    in_req_type     = req;
    in_region_start = lo;
    in_region_end   = hi;
    in_region_attr  = attr;
    start           = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req != REQ_IGNORED && !(req == mmrs_pkg::REQ_LOAD && rsv_count >= RSV_DEPTH))
      beats_sent++;
    splice_beat(req, lo, hi, attr, cut);
    if (pinned) due_pieces.push_back(want);
    else foreach (cut[k]) due_pieces.push_back(cut[k]);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted piece has come out.
  task automatic wait_for_results();
    start = 1'b0;
    while (due_pieces.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] lo,
                                  input logic [ADDR_W-1:0] hi, input logic [ATTR_W-1:0] attr,
                                  input int reps, input bit pinned, input bit settle,
                                  input piece_t want);
    script_row_t r;
    r.req    = req;
    r.lo     = lo;
    r.hi     = hi;
    r.attr   = attr;
    r.reps   = reps;
    r.pinned = pinned;
    r.settle = settle;
    r.want   = want;
    script.push_back(r);
  endfunction

  // Directed part: every request type, each slicing branch, both error paths,
  // a full table, an empty list and the address extremes.
  function automatic void build_script();
    // Terminator right after reset.
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b1, mmrs_pkg::ERR_NONE));
    // Empty table: the whole region is one tail piece.
    add_row(mmrs_pkg::REQ_REGION, 64'h1000, 64'h2000, 32'hA5A5_0001, 1, 1, 0,
            piece(64'h1000, 64'h2000, 32'hA5A5_0001, 1'b1, 1'b0, mmrs_pkg::ERR_NONE));
    // Inverted and empty regions are counted but give nothing.
    add_row(mmrs_pkg::REQ_REGION, 64'h3000, 64'h2000, 32'h1, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, '1, '1, '1, 1, 0, 0, '0);
    // Top of the address space, all attribute bits set.
    add_row(mmrs_pkg::REQ_REGION, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 1, 1, 0,
            piece(64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 1'b1, 1'b0, mmrs_pkg::ERR_NONE));
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b1, mmrs_pkg::ERR_NONE));
    // Three sorted reservations, then regions that hit every slicing branch.
    add_row(mmrs_pkg::REQ_LOAD, 64'h1000, 64'h1800, 32'h11, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_LOAD, 64'h3000, 64'h4000, 32'h22, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_LOAD, 64'h5000, 64'h6000, 32'h33, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, 64'h800, 64'h3800, 32'hAA, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, 64'h5400, 64'h7000, 32'hBB, 1, 0, 0, '0);
    add_row(REQ_IGNORED, 64'h1234, 64'h5678, 32'hCC, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 1, 1,
            piece('0, '0, '0, 1'b1, 1'b1, mmrs_pkg::ERR_NONE));
    // Fill the region count, then both a region and a terminator hit the limit.
    add_row(mmrs_pkg::REQ_REGION, 64'h9000, 64'h8000, 32'h1, REGION_CAP, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, 64'h100, 64'h200, 32'h2, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b0, mmrs_pkg::ERR_LIMIT));
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b0, mmrs_pkg::ERR_LIMIT));
    add_row(mmrs_pkg::REQ_CLEAR, '0, '0, '0, 1, 0, 1, '0);
    // Start at zero with no list: empty pieces until the output overflows.
    add_row(mmrs_pkg::REQ_REGION, '0, '1, 32'h5, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, 64'h10, 64'h20, 32'h6, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b0, mmrs_pkg::ERR_OVERFLOW));
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 1, 0,
            piece('0, '0, '0, 1'b1, 1'b1, mmrs_pkg::ERR_OVERFLOW));
    add_row(mmrs_pkg::REQ_CLEAR, '1, '1, '1, 1, 0, 0, '0);
    // One more load than the table holds; the region then walks every row.
    add_row(mmrs_pkg::REQ_LOAD, 64'h100, 64'h200, 32'h77, RSV_DEPTH + 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, 64'h100, 64'h300, 32'h99, 1, 0, 0, '0);
    add_row(mmrs_pkg::REQ_REGION, '0, '0, '0, 1, 0, 1, '0);
    add_row(mmrs_pkg::REQ_CLEAR, '0, '0, '0, 1, 0, 0, '0);
  endfunction

  function automatic logic [ADDR_W-1:0] gap_len();
    return ($urandom_range(0, 3) == 0) ? '0 : ADDR_W'($urandom_range(1, 16'hFFFF));
  endfunction

  // Random map: clear, sorted reservations, a walk of mostly adjacent regions and a
  // terminator, with some noise mixed in.
  task automatic build_map();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    int                pick;
    int                n_resv;
    int                n_reg;
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 8 || regions_seen >= REGION_CAP) begin
      sender_gap();
      send_beat(mmrs_pkg::REQ_CLEAR, rnd64(), rnd64(), $urandom, 0, '0);
    end
    pick = $urandom_range(0, 19);
    if (pick < 14) n_resv = $urandom_range(0, 5);
    else if (pick < 19) n_resv = $urandom_range(6, RSV_DEPTH);
    else n_resv = $urandom_range(RSV_DEPTH + 1, RSV_DEPTH + 4);
    // Leave headroom above the base so the walk does not wrap.
    base = {32'($urandom_range(1, 32'hFFFF_FF00)), $urandom};
    cur = base;
    repeat (n_resv) begin
      lo = cur + gap_len();
      hi = lo + (($urandom_range(0, 15) == 0) ? '0 : ADDR_W'($urandom_range(1, 16'hFFFF)));
      if ($urandom_range(0, 19) == 0) begin
        lo = rnd64();
        hi = rnd64();
      end
      sender_gap();
      send_beat(mmrs_pkg::REQ_LOAD, lo, hi, $urandom, 0, '0);
      cur = hi;
    end
    pick = $urandom_range(0, 19);
    if (pick < 16) n_reg = $urandom_range(1, 6);
    else if (pick < 19) n_reg = $urandom_range(7, 20);
    else n_reg = $urandom_range(REGION_CAP - 2, REGION_CAP + 2);
    cur = base - ADDR_W'($urandom_range(0, 16'hFFFF));
    repeat (n_reg) begin
      lo = cur + (($urandom_range(0, 2) == 0) ? gap_len() : '0);
      hi = lo + ADDR_W'($urandom_range(1, 1 << $urandom_range(4, 20)));
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        lo = rnd64();
        hi = rnd64();
      end else if (pick == 1) begin
        lo = '0;
      end else if (pick == 2) begin
        sender_gap();
        send_beat(REQ_IGNORED, rnd64(), rnd64(), $urandom, 0, '0);
      end
      sender_gap();
      send_beat(mmrs_pkg::REQ_REGION, lo, hi, $urandom, 0, '0);
      cur = hi;
    end
    if ($urandom_range(0, 3) == 0) wait_for_results();
    if ($urandom_range(0, 9) != 0) begin
      sender_gap();
      send_beat(mmrs_pkg::REQ_REGION, '0, '0, $urandom, 0, '0);
    end
  endtask

  initial begin : stimulus
    script_row_t r;
    start           = 1'b0;
    rst_n           = 1'b0;
    in_req_type     = mmrs_pkg::REQ_CLEAR;
    in_region_start = '0;
    in_region_end   = '0;
    in_region_attr  = '0;
    mismatches      = 0;
    beats_sent      = 0;
    steady          = 1'b0;
    forget_map();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    build_script();
    foreach (script[i]) begin
      r = script[i];
      if (r.settle) wait_for_results();
      repeat (r.reps) begin
        sender_gap();
        send_beat(r.req, r.lo, r.hi, r.attr, r.pinned, r.want);
      end
    end

    while (beats_sent < RANDOM_ITEMS) build_map();

    // Drain, then give stray beats a chance to show up.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (due_pieces.size() != 0) begin
      $display("%0t: %0d expected pieces never came out", $time, due_pieces.size());
      mismatches++;
    end
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: every strobed beat is compared against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    piece_t want;
    if (rst_n && out_valid) begin
      if (due_pieces.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $display("%0t: unexpected beat: expected none, actual start=%h end=%h err=%0d",
                   $time, out_start, out_end, out_error_code);
        mismatches++;
      end else begin
        want = due_pieces.pop_front();
        compare_field("out_start", want.lo, out_start);
        compare_field("out_end", want.hi, out_end);
        compare_field("out_attr", ADDR_W'(want.attr), ADDR_W'(out_attr));
        compare_field("out_last_of_run", ADDR_W'(want.last), ADDR_W'(out_last_of_run));
        compare_field("out_map_end", ADDR_W'(want.map_end), ADDR_W'(out_map_end));
        compare_field("out_error_code", ADDR_W'(want.err), ADDR_W'(out_error_code));
      end
    end
  end

  // Watchdog: any beat on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d pieces pending", $time, quiet_cycles,
               due_pieces.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

endmodule
